/* hw/rtl/hslrgb_pkg.sv */
package hslrgb_pkg;

  // Fixed-point format of the internal levels: ONE = 2^FRACTION_BITS.
  localparam int FRACTION_BITS = 8;
  localparam int Q_W           = FRACTION_BITS + 1;   // holds 0..ONE
  localparam logic [Q_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Register and field widths
  localparam int REG_W   = 9;
  localparam int HUE_W   = 9;
  localparam int LEVEL_W = 8;
  localparam int HM_W    = 7;   // hue within a 120 degree span
  localparam int TRI_W   = 6;   // triangle weight 0..60
  localparam int PROD_W  = Q_W + TRI_W;

  localparam logic [REG_W-1:0] REG_FULL = REG_W'(256);
  localparam logic [HUE_W-1:0] HUE_MAX  = HUE_W'(359);

  // Register index codes
  typedef enum logic {
    REG_SATURATION = 1'b0,
    REG_LIGHTNESS  = 1'b1
  } reg_index_t;

  // 60 degree sector of the hue
  typedef enum logic [2:0] {
    SECT_RED_YEL   = 3'd0,
    SECT_YEL_GRN   = 3'd1,
    SECT_GRN_CYN   = 3'd2,
    SECT_CYN_BLU   = 3'd3,
    SECT_BLU_MAG   = 3'd4,
    SECT_MAG_RED   = 3'd5
  } sector_t;

  // Register value (1/256 units) to Q format
  localparam int Q_UP   = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
  localparam int Q_DOWN = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;

  // floor(n/15) = ((n+1) * (2^S-1)/15) >> S, exact while n+1 < 2^S
  localparam int DIV15_SHIFT = ((FRACTION_BITS + 4 + 3) / 4) * 4;
  localparam int DIV15_W     = DIV15_SHIFT;
  localparam logic [DIV15_W-1:0] DIV15_MULT = DIV15_W'(((1 << DIV15_SHIFT) - 1) / 15);
  localparam int DIV60_PW    = PROD_W - 1 + DIV15_W;

  function automatic logic [Q_W-1:0] reg_to_q(input logic [REG_W-1:0] r);
    logic [REG_W-1:0]     rc;
    logic [Q_W+REG_W-1:0] wide;
    rc   = (r > REG_FULL) ? REG_FULL : r;
    wide = ((Q_W + REG_W)'(rc) << Q_UP) >> Q_DOWN;
    return wide[Q_W-1:0];
  endfunction

  // floor(p / 60) via floor(floor(p/4) / 15)
  function automatic logic [Q_W-1:0] div60(input logic [PROD_W-1:0] p);
    logic [PROD_W-2:0]   n1;
    logic [DIV60_PW-1:0] prod;
    n1   = (PROD_W - 1)'(p >> 2) + (PROD_W - 1)'(1);
    prod = DIV60_PW'(n1) * DIV60_PW'(DIV15_MULT);
    return prod[DIV15_SHIFT +: Q_W];
  endfunction

  // floor(v * k / 255) for an 8-bit level, k = 31 or 63
  function automatic logic [5:0] scale255(input logic [LEVEL_W-1:0] v,
                                          input logic [5:0] k);
    logic [13:0] p;
    logic [14:0] t;
    p = 14'(v) * 14'(k);
    t = 15'(p) + 15'(p >> 8) + 15'(1);
    return t[13:8];
  endfunction

endpackage

/* hw/rtl/hsl_to_rgb565_converter.sv */
// HSL to RGB converter. Each beat on the input carries a hue in whole degrees
// (360 and above are taken as 359); saturation and lightness come from two
// configuration registers in 1/256 units (index 0 saturation, reset 256 = full;
// index 1 lightness, reset 154 ~ 0.6; values above 256 act as 256). Each
// output beat carries truncated 8-bit R, G and B and the matching RGB565 word
// (red 15:11, green 10:5, blue 4:0). The datapath is a five-stage pipeline:
// chroma, sector and triangle product, divide by 60, channel levels, RGB565
// packing, with the last stage as the output register. While the output is
// not stalled a beat can enter every cycle, so throughput is one colour per
// clock; an accepted beat loads stage one and moves through the stages in
// order, output valid rising as it loads the output register. Each stage holds
// its beat while the stage after it is full and stalled; empty stages still
// take new beats, so input ready only drops when every stage is occupied and
// the output is not taken.
// Registers may only be written while the pipeline is empty.
module hsl_to_rgb565_converter (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [hslrgb_pkg::REG_W-1:0]     cfg_data,
  // input beats
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hslrgb_pkg::HUE_W-1:0]     hue_degrees,
  // output beats
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hslrgb_pkg::LEVEL_W-1:0]   red_level,
  output logic [hslrgb_pkg::LEVEL_W-1:0]   green_level,
  output logic [hslrgb_pkg::LEVEL_W-1:0]   blue_level,
  output logic [15:0]                      rgb565_word
);

  localparam int Q_W = hslrgb_pkg::Q_W;
  localparam int LW  = hslrgb_pkg::LEVEL_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [hslrgb_pkg::REG_W-1:0] saturation;
  logic [hslrgb_pkg::REG_W-1:0] lightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= hslrgb_pkg::REG_W'(256);
      lightness  <= hslrgb_pkg::REG_W'(154);
    end else if (cfg_write) begin
      unique case (hslrgb_pkg::reg_index_t'(cfg_index))
        hslrgb_pkg::REG_SATURATION: saturation <= cfg_data;
        hslrgb_pkg::REG_LIGHTNESS:  lightness  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage valids and back-pressure: a stage loads when it is empty or
  // its beat moves on in the same cycle.
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: hue clamp, chroma c = (ONE - |2L - ONE|) * S / ONE
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]   s_q, l_q;
  logic [Q_W:0]     twice_l;
  logic [Q_W:0]     one_w;
  logic [Q_W-1:0]   l_offset;
  logic [2*Q_W-1:0] c_prod;
  logic [Q_W-1:0]   chroma_next;
  logic [hslrgb_pkg::HUE_W-1:0] hue_next;

  logic [hslrgb_pkg::HUE_W-1:0] hue1;
  logic [Q_W-1:0]               chroma1;
  logic [Q_W:0]                 tl1;

  always_comb begin
    s_q      = hslrgb_pkg::reg_to_q(saturation);
    l_q      = hslrgb_pkg::reg_to_q(lightness);
    twice_l  = {l_q, 1'b0};
    one_w    = (Q_W + 1)'(hslrgb_pkg::ONE);
    l_offset = (twice_l >= one_w) ? Q_W'(twice_l - one_w) : Q_W'(one_w - twice_l);
    c_prod   = (2*Q_W)'(hslrgb_pkg::ONE - l_offset) * (2*Q_W)'(s_q);
    chroma_next = (l_offset >= hslrgb_pkg::ONE) ? '0 :
                  c_prod[hslrgb_pkg::FRACTION_BITS +: Q_W];
    hue_next = (hue_degrees > hslrgb_pkg::HUE_MAX) ? hslrgb_pkg::HUE_MAX : hue_degrees;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      hue1    <= hue_next;
      chroma1 <= chroma_next;
      tl1     <= twice_l;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sector, triangle weight 60 - |(h mod 120) - 60|, c * weight
  // ---------------------------------------------------------------------
  logic [hslrgb_pkg::HM_W-1:0]  hm;
  logic [2:0]                   sect_base;
  logic [hslrgb_pkg::TRI_W-1:0] tri_w;
  hslrgb_pkg::sector_t          sector_next;

  hslrgb_pkg::sector_t               sector2;
  logic [hslrgb_pkg::PROD_W-1:0]     p2;
  logic [Q_W-1:0]                    chroma2;
  logic [Q_W:0]                      tl2;

  always_comb begin
    if (hue1 >= hslrgb_pkg::HUE_W'(240)) begin
      hm        = hslrgb_pkg::HM_W'(hue1 - hslrgb_pkg::HUE_W'(240));
      sect_base = 3'd4;
    end else if (hue1 >= hslrgb_pkg::HUE_W'(120)) begin
      hm        = hslrgb_pkg::HM_W'(hue1 - hslrgb_pkg::HUE_W'(120));
      sect_base = 3'd2;
    end else begin
      hm        = hslrgb_pkg::HM_W'(hue1);
      sect_base = 3'd0;
    end
    if (hm >= hslrgb_pkg::HM_W'(60)) begin
      tri_w       = hslrgb_pkg::TRI_W'(hslrgb_pkg::HM_W'(120) - hm);
      sector_next = hslrgb_pkg::sector_t'(sect_base + 3'd1);
    end else begin
      tri_w       = hslrgb_pkg::TRI_W'(hm);
      sector_next = hslrgb_pkg::sector_t'(sect_base);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sector2 <= sector_next;
      p2      <= hslrgb_pkg::PROD_W'(chroma1) * hslrgb_pkg::PROD_W'(tri_w);
      chroma2 <= chroma1;
      tl2     <= tl1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: secondary x = floor(c * weight / 60)
  // ---------------------------------------------------------------------
  hslrgb_pkg::sector_t sector3;
  logic [Q_W-1:0]      x3;
  logic [Q_W-1:0]      chroma3;
  logic [Q_W:0]        tl3;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sector3 <= sector2;
      x3      <= hslrgb_pkg::div60(p2);
      chroma3 <= chroma2;
      tl3     <= tl2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: place c, x and 0 by sector, then form the 8-bit levels
  // ---------------------------------------------------------------------
  logic [Q_W-1:0] n_red, n_green, n_blue;
  logic [LW-1:0]  red_next, green_next, blue_next;
  logic [LW-1:0]  red4, green4, blue4;

  always_comb begin
    unique case (sector3)
      hslrgb_pkg::SECT_RED_YEL: begin
        n_red = chroma3; n_green = x3;      n_blue = '0;
      end
      hslrgb_pkg::SECT_YEL_GRN: begin
        n_red = x3;      n_green = chroma3; n_blue = '0;
      end
      hslrgb_pkg::SECT_GRN_CYN: begin
        n_red = '0;      n_green = chroma3; n_blue = x3;
      end
      hslrgb_pkg::SECT_CYN_BLU: begin
        n_red = '0;      n_green = x3;      n_blue = chroma3;
      end
      hslrgb_pkg::SECT_BLU_MAG: begin
        n_red = x3;      n_green = '0;      n_blue = chroma3;
      end
      hslrgb_pkg::SECT_MAG_RED: begin
        n_red = chroma3; n_green = '0;      n_blue = x3;
      end
      default: begin
        n_red = '0;      n_green = '0;      n_blue = '0;
      end
    endcase
  end

  hslrgb_level u_level_red (
    .n       (n_red),
    .twice_l (tl3),
    .chroma  (chroma3),
    .level   (red_next)
  );

  hslrgb_level u_level_green (
    .n       (n_green),
    .twice_l (tl3),
    .chroma  (chroma3),
    .level   (green_next)
  );

  hslrgb_level u_level_blue (
    .n       (n_blue),
    .twice_l (tl3),
    .chroma  (chroma3),
    .level   (blue_next)
  );

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      red4   <= red_next;
      green4 <= green_next;
      blue4  <= blue_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: RGB565 packing, output register
  // ---------------------------------------------------------------------
  logic [5:0] r5_wide, g6, b5_wide;

  always_comb begin
    r5_wide = hslrgb_pkg::scale255(red4, 6'd31);
    g6      = hslrgb_pkg::scale255(green4, 6'd63);
    b5_wide = hslrgb_pkg::scale255(blue4, 6'd31);
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      red_level   <= red4;
      green_level <= green4;
      blue_level  <= blue4;
      rgb565_word <= {r5_wide[4:0], g6, b5_wide[4:0]};
    end
  end

endmodule

/* hw/rtl/hslrgb_level.sv */
// One colour channel: floor((2n + 2L - c) * 255 / (2 * ONE)), clamped.
module hslrgb_level (
  input  logic [hslrgb_pkg::Q_W-1:0]     n,
  input  logic [hslrgb_pkg::Q_W:0]       twice_l,
  input  logic [hslrgb_pkg::Q_W-1:0]     chroma,
  output logic [hslrgb_pkg::LEVEL_W-1:0] level
);

  localparam int SUM_W = hslrgb_pkg::Q_W + 2;
  localparam int V2_W  = hslrgb_pkg::Q_W + 1;
  localparam int MUL_W = V2_W + 8;
  localparam logic [SUM_W-1:0] TWO_ONE = SUM_W'({hslrgb_pkg::ONE, 1'b0});

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] diff;
  logic [V2_W-1:0]  v2;
  logic [MUL_W-1:0] prod;

  always_comb begin
    sum  = SUM_W'({n, 1'b0}) + SUM_W'(twice_l);
    diff = (sum > SUM_W'(chroma)) ? sum - SUM_W'(chroma) : '0;
    v2   = (diff > TWO_ONE) ? V2_W'(TWO_ONE) : V2_W'(diff);
    prod = MUL_W'(v2) * MUL_W'(255);
    // v2 <= 2*ONE keeps the result at 255 or below
    level = prod[hslrgb_pkg::FRACTION_BITS + 1 +: hslrgb_pkg::LEVEL_W];
  end

endmodule
